@@ src/nmea_gga_pkg.sv @@
// shared types, codes and constants for the gga field extractor
package nmea_gga_pkg;

  // default capacity of each text field, in characters
  localparam int unsigned FieldCapDefault = 15;

  // recognizer state codes
  localparam logic [4:0] ST_HUNT      = 5'd0;
  localparam logic [4:0] ST_HDR_G1    = 5'd1;
  localparam logic [4:0] ST_HDR_P     = 5'd2;
  localparam logic [4:0] ST_HDR_G2    = 5'd3;
  localparam logic [4:0] ST_HDR_G3    = 5'd4;
  localparam logic [4:0] ST_HDR_A     = 5'd5;
  localparam logic [4:0] ST_HDR_COMMA = 5'd6;
  localparam logic [4:0] ST_TIME      = 5'd7;
  localparam logic [4:0] ST_LAT       = 5'd8;
  localparam logic [4:0] ST_LAT_HEMI  = 5'd9;
  localparam logic [4:0] ST_LON       = 5'd10;
  localparam logic [4:0] ST_LON_HEMI  = 5'd11;
  localparam logic [4:0] ST_FIX       = 5'd12;
  localparam logic [4:0] ST_SATS      = 5'd13;
  localparam logic [4:0] ST_HDOP      = 5'd14;
  localparam logic [4:0] ST_ALT       = 5'd15;
  localparam logic [4:0] ST_ALT_UNIT  = 5'd16;
  localparam logic [4:0] ST_GEOID     = 5'd17;
  localparam logic [4:0] ST_GEOID_UNT = 5'd18;
  localparam logic [4:0] ST_DIFF_AGE  = 5'd19;
  localparam logic [4:0] ST_TO_STAR   = 5'd20;
  localparam logic [4:0] ST_TO_NL     = 5'd21;
  localparam logic [4:0] ST_DONE      = 5'd22;

  // write target codes
  localparam logic [2:0] SEL_NONE = 3'd0;
  localparam logic [2:0] SEL_TIME = 3'd1;
  localparam logic [2:0] SEL_LAT  = 3'd2;
  localparam logic [2:0] SEL_LON  = 3'd3;
  localparam logic [2:0] SEL_ALT  = 3'd4;
  localparam logic [2:0] SEL_FIX  = 3'd5;

  // index of each field length counter
  localparam logic [1:0] LEN_TIME = 2'd0;
  localparam logic [1:0] LEN_LAT  = 2'd1;
  localparam logic [1:0] LEN_LON  = 2'd2;
  localparam logic [1:0] LEN_ALT  = 2'd3;

  // ascii characters
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_G       = 8'h47;
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_ZERO    = 8'd48;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [2:0] field_sel;
    logic [3:0] write_pos;
    logic [7:0] char_value;
    logic       sentence_done;
    logic       overflow;
  } out_t;

endpackage

@@ src/nmea_gga_parse.sv @@
// next-state and result logic for one received byte
module nmea_gga_parse #(
  parameter int unsigned FIELD_CAP = nmea_gga_pkg::FieldCapDefault,
  localparam int unsigned LenW = $clog2(FIELD_CAP + 1)
) (
  input  nmea_gga_pkg::in_t        item_i,
  input  logic [4:0]               state_i,
  input  logic [3:0][LenW-1:0]     len_i,
  input  logic                     done_i,
  output logic [4:0]               state_o,
  output logic [3:0][LenW-1:0]     len_o,
  output logic                     done_o,
  output nmea_gga_pkg::out_t       result_o
);
  import nmea_gga_pkg::*;

  logic [4:0]           state_e;
  logic [3:0][LenW-1:0] len_e;
  logic                 done_e;
  logic [7:0]           c;
  logic                 comma;
  logic                 wr_en;
  logic                 wr_adv;
  logic [1:0]           wr_idx;
  logic [2:0]           wr_sel;
  logic [LenW-1:0]      wr_len;
  logic                 wr_full;
  logic [3:0]           pos_ext;
  out_t                 base_res;

  assign c     = item_i.rx_byte;
  assign comma = (c == CH_COMMA);

  // restart takes effect before this byte
  assign state_e = item_i.restart ? ST_HUNT : state_i;
  assign len_e   = item_i.restart ? '0 : len_i;
  assign done_e  = item_i.restart ? 1'b0 : done_i;

  always_comb begin
    state_o  = state_e;
    done_o   = done_e;
    wr_en    = 1'b0;
    wr_adv   = 1'b1;
    wr_idx   = LEN_TIME;
    wr_sel   = SEL_NONE;
    base_res = '0;
    case (state_e)
      ST_HUNT:      state_o = (c == CH_DOLLAR) ? ST_HDR_G1 : ST_HUNT;
      ST_HDR_G1:    state_o = (c == CH_G) ? ST_HDR_P : ST_HUNT;
      ST_HDR_P:     state_o = (c == CH_P) ? ST_HDR_G2 : ST_HUNT;
      ST_HDR_G2:    state_o = (c == CH_G) ? ST_HDR_G3 : ST_HUNT;
      ST_HDR_G3:    state_o = (c == CH_G) ? ST_HDR_A : ST_HUNT;
      ST_HDR_A:     state_o = (c == CH_A) ? ST_HDR_COMMA : ST_HUNT;
      ST_HDR_COMMA: state_o = comma ? ST_TIME : ST_HUNT;
      ST_TIME: begin
        if (comma) state_o = ST_LAT;
        else begin
          wr_en = 1'b1; wr_idx = LEN_TIME; wr_sel = SEL_TIME;
        end
      end
      ST_LAT: begin
        if (comma) state_o = ST_LAT_HEMI;
        else begin
          wr_en = 1'b1; wr_idx = LEN_LAT; wr_sel = SEL_LAT;
        end
      end
      ST_LAT_HEMI: begin
        if (comma) state_o = ST_LON;
        else begin
          wr_en = 1'b1; wr_idx = LEN_LAT; wr_sel = SEL_LAT; wr_adv = 1'b0;
        end
      end
      ST_LON: begin
        if (comma) state_o = ST_LON_HEMI;
        else begin
          wr_en = 1'b1; wr_idx = LEN_LON; wr_sel = SEL_LON;
        end
      end
      ST_LON_HEMI: begin
        if (comma) state_o = ST_FIX;
        else begin
          wr_en = 1'b1; wr_idx = LEN_LON; wr_sel = SEL_LON; wr_adv = 1'b0;
        end
      end
      ST_FIX: begin
        if (comma) state_o = ST_SATS;
        else begin
          base_res.field_sel  = SEL_FIX;
          base_res.char_value = c - CH_ZERO;
        end
      end
      ST_SATS, ST_HDOP, ST_ALT_UNIT, ST_GEOID, ST_GEOID_UNT, ST_DIFF_AGE: begin
        if (comma) state_o = state_e + 5'd1;
      end
      ST_ALT: begin
        if (comma) state_o = ST_ALT_UNIT;
        else begin
          wr_en = 1'b1; wr_idx = LEN_ALT; wr_sel = SEL_ALT;
        end
      end
      ST_TO_STAR: begin
        if (c == CH_STAR) state_o = ST_TO_NL;
      end
      ST_TO_NL: begin
        if (c == CH_NEWLINE) begin
          state_o = ST_DONE;
          done_o  = 1'b1;
        end
      end
      default: state_o = ST_HUNT;
    endcase
  end

  always_comb begin
    result_o = base_res;
    if (wr_en) begin
      result_o.field_sel  = wr_sel;
      result_o.write_pos  = pos_ext;
      result_o.char_value = c;
      result_o.overflow   = wr_full;
    end
    result_o.sentence_done = done_o;
  end

  assign wr_len  = len_e[wr_idx];
  assign wr_full = (wr_len >= LenW'(FIELD_CAP));
  assign pos_ext = 4'(wr_len);

  always_comb begin
    len_o = len_e;
    if (wr_en && wr_adv && !wr_full) begin
      len_o[wr_idx] = wr_len + LenW'(1);
    end
  end

endmodule

@@ src/nmea_gga_field_extractor_unit.sv @@
// top level of the gga sentence field extractor
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-------------------------------
//  input    | in  | in_valid_i/in_ready_o   | in_data_i  (rx_byte, restart)
//  result   | out | out_valid_o/out_ready_i | out_data_o (field write, flags)
//
// one transaction in, one transaction out; a byte every cycle sustained while results are accepted
// each byte passes the input register, then parse logic into the result register
// the recognizer state and field lengths update when a byte moves into the result register
// reset clears state, lengths, done flag and both valid bits at once; no clearing pass
// a stalled result holds the parse stage, and the input register then fills and drops ready
module nmea_gga_field_extractor_unit #(
  parameter int unsigned FIELD_CAP = nmea_gga_pkg::FieldCapDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nmea_gga_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nmea_gga_pkg::out_t out_data_o
);
  import nmea_gga_pkg::*;

  localparam int unsigned LenW = $clog2(FIELD_CAP + 1);

  // input register
  logic in_valid_q;
  in_t  in_q;

  // recognizer state
  logic [4:0]           state_q, state_d;
  logic [3:0][LenW-1:0] len_q, len_d;
  logic                 done_q, done_d;

  // result register
  logic out_valid_q;
  out_t out_q, out_d;

  logic advance;

  // the parse stage moves when it holds a byte and the result slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  nmea_gga_parse #(
    .FIELD_CAP (FIELD_CAP)
  ) u_parse (
    .item_i   (in_q),
    .state_i  (state_q),
    .len_i    (len_q),
    .done_i   (done_q),
    .state_o  (state_d),
    .len_o    (len_d),
    .done_o   (done_d),
    .result_o (out_d)
  );

  // state commits only with a byte that leaves the parse stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      len_q   <= '0;
      done_q  <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
      len_q   <= len_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // field lengths never pass the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q[0] <= LenW'(FIELD_CAP)) && (len_q[1] <= LenW'(FIELD_CAP)) &&
    (len_q[2] <= LenW'(FIELD_CAP)) && (len_q[3] <= LenW'(FIELD_CAP)))
    else $error("field length beyond capacity");

  // done flag only drops on a restart byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !(advance && in_q.restart) |=> done_q)
    else $error("done flag cleared without restart");

  // state and lengths hold while the parse stage is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q) && $stable(len_q))
    else $error("parse state changed without a byte");

  // overflow only on a text field write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.overflow |->
      (out_q.field_sel == SEL_TIME || out_q.field_sel == SEL_LAT ||
       out_q.field_sel == SEL_LON || out_q.field_sel == SEL_ALT))
    else $error("overflow on a non-text target");

  // a stalled byte in the input register is kept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("input register lost a stalled byte");

endmodule
